FILE: src/http_chunked_body_decoder_macros.svh
// Assertion macros used by the checker file of the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HCBD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HCBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: src/hcbd_pkg.sv
// Shared types and constants of the chunked body decoder.
`timescale 1ns / 1ps

package hcbd_pkg;

	// Width of the chunk size accumulator; saturates at all ones.
	localparam int SIZE_BITS = 32;
	localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};
	localparam logic [SIZE_BITS-1:0] SIZE_ZERO = {SIZE_BITS{1'b0}};
	localparam logic [SIZE_BITS-1:0] SIZE_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

	// Line delimiters
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Result status codes
	localparam logic [1:0] STATUS_BUSY  = 2'd0;
	localparam logic [1:0] STATUS_OK    = 2'd1;
	localparam logic [1:0] STATUS_ERROR = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       finished;
		logic [1:0] status;
	} out_item_t;

endpackage

FILE: src/hcbd_in_reg.sv
// Input register stage of the chunked body decoder.
`timescale 1ns / 1ps

module hcbd_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               chunk_valid,
	output logic               chunk_ready,
	input  hcbd_pkg::in_item_t chunk,
	input  logic               fire,
	output logic               valid_s1,
	output hcbd_pkg::in_item_t item_s1
);

	// Room when empty or when the held byte is consumed this cycle
	assign chunk_ready = !valid_s1 || fire;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chunk_ready) begin
			valid_s1 <= chunk_valid;
		end
	end

	// Payload, loaded on transfer
	always_ff @(posedge clk) begin
		if (chunk_valid && chunk_ready) begin
			item_s1 <= chunk;
		end
	end

endmodule

FILE: src/hcbd_core.sv
// Chunk framing state machine: size line parse, payload count, trailer skip.
`timescale 1ns / 1ps

module hcbd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  hcbd_pkg::in_item_t  item,
	input  logic                fire,
	output logic                produce,
	output hcbd_pkg::out_item_t res
);

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_DATA,
		PH_TRAIL1,
		PH_TRAIL2,
		PH_DONE
	} phase_t;

	phase_t                          phase_q, phase_n;
	logic [hcbd_pkg::SIZE_BITS-1:0] acc_q, acc_n;
	logic                            stopped_q, stopped_n;
	logic                            cr_q, cr_n;
	logic [4:0]                      hex;
	logic                            restart;

	// {is_hex, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0_0000;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	assign hex = hex_decode(item.in_byte);

	// Next state and result for the byte at hand
	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		stopped_n = stopped_q;
		cr_n      = cr_q;
		restart   = 1'b0;
		produce   = 1'b0;
		res       = '0;
		case (phase_q)
			PH_DATA: begin
				acc_n   = acc_q - hcbd_pkg::SIZE_ONE;
				if (acc_q == hcbd_pkg::SIZE_ONE) begin
					phase_n = PH_TRAIL1;
				end
				produce        = 1'b1;
				res.out_byte   = item.in_byte;
				res.byte_valid = 1'b1;
				if (item.end_of_input) begin
					restart      = 1'b1;
					res.finished = 1'b1;
					res.status   = hcbd_pkg::STATUS_ERROR;
				end
			end
			PH_TRAIL1: begin
				phase_n = PH_TRAIL2;
				if (item.end_of_input) begin
					restart      = 1'b1;
					produce      = 1'b1;
					res.finished = 1'b1;
					res.status   = hcbd_pkg::STATUS_ERROR;
				end
			end
			PH_TRAIL2: begin
				restart = 1'b1;
				if (item.end_of_input) begin
					produce      = 1'b1;
					res.finished = 1'b1;
					res.status   = hcbd_pkg::STATUS_ERROR;
				end
			end
			PH_DONE: begin
				// trailer after the last chunk is dropped
				restart = item.end_of_input;
			end
			PH_SIZE: begin
				if (cr_q && item.in_byte == hcbd_pkg::CHAR_LF) begin
					if (acc_q == hcbd_pkg::SIZE_ZERO) begin
						// zero chunk: body complete
						produce      = 1'b1;
						res.finished = 1'b1;
						res.status   = hcbd_pkg::STATUS_OK;
						if (item.end_of_input) begin
							restart = 1'b1;
						end else begin
							phase_n = PH_DONE;
						end
					end else begin
						phase_n   = PH_DATA;
						stopped_n = 1'b0;
						cr_n      = 1'b0;
						if (item.end_of_input) begin
							restart      = 1'b1;
							produce      = 1'b1;
							res.finished = 1'b1;
							res.status   = hcbd_pkg::STATUS_ERROR;
						end
					end
				end else begin
					cr_n = (item.in_byte == hcbd_pkg::CHAR_CR);
					if (!stopped_q) begin
						if (!hex[4]) begin
							stopped_n = 1'b1;
						end else if (acc_q[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'h0) begin
							acc_n = hcbd_pkg::SIZE_MAX;
						end else begin
							acc_n = {acc_q[hcbd_pkg::SIZE_BITS-5:0], hex[3:0]};
						end
					end
					if (item.end_of_input) begin
						restart      = 1'b1;
						produce      = 1'b1;
						res.finished = 1'b1;
						res.status   = hcbd_pkg::STATUS_ERROR;
					end
				end
			end
			default: begin
				restart = 1'b1;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIZE;
			acc_q     <= hcbd_pkg::SIZE_ZERO;
			stopped_q <= 1'b0;
			cr_q      <= 1'b0;
		end else if (fire) begin
			if (restart) begin
				phase_q   <= PH_SIZE;
				acc_q     <= hcbd_pkg::SIZE_ZERO;
				stopped_q <= 1'b0;
				cr_q      <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				acc_q     <= acc_n;
				stopped_q <= stopped_n;
				cr_q      <= cr_n;
			end
		end
	end

endmodule

FILE: src/hcbd_out_reg.sv
// Result register stage of the chunked body decoder.
`timescale 1ns / 1ps

module hcbd_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  hcbd_pkg::out_item_t load_data,
	output logic                free,
	output logic                result_valid,
	input  logic                result_ready,
	output hcbd_pkg::out_item_t result
);

	// Slot can take a new result when empty or being drained
	assign free = !result_valid || result_ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (free) begin
			result_valid <= load;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load && free) begin
			result <= load_data;
		end
	end

endmodule

FILE: src/http_chunked_body_decoder.sv
// Chunked body decoder top level: input register, framing core, result register.
// Takes one byte of an HTTP/1.1 chunked body per cycle and returns payload bytes and a
// final status; throughput is one byte per clock unless a result meets a full result
// slot, set by the update of the framing state (phase, size counter, line flags) in
// the core; a byte's result passes the input and result registers. Size lines are
// read as leading hex digits and saturate at all ones; payload bytes come out with
// status 0; a zero chunk gives one result with finished set and status 1, and an input
// that ends early gives finished with status 2, so the consumer drops the bytes of that
// body. Bytes that cause no result (size lines, trailers, anything after the zero
// chunk) are absorbed without waiting on the result side. No clearing pass after reset.
`timescale 1ns / 1ps

module http_chunked_body_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                chunk_valid,
	output logic                chunk_ready,
	input  hcbd_pkg::in_item_t  chunk,
	output logic                result_valid,
	input  logic                result_ready,
	output hcbd_pkg::out_item_t result
);

	logic                valid_s1;
	hcbd_pkg::in_item_t  item_s1;
	logic                fire;
	logic                produce;
	logic                free;
	hcbd_pkg::out_item_t res;

	// Byte advances unless it has a result and the result slot is full
	assign fire = valid_s1 && (!produce || free);

	hcbd_in_reg u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.chunk_valid (chunk_valid),
		.chunk_ready (chunk_ready),
		.chunk       (chunk),
		.fire        (fire),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1)
	);

	hcbd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.fire    (fire),
		.produce (produce),
		.res     (res)
	);

	hcbd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire && produce),
		.load_data    (res),
		.free         (free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: src/hcbd_checker.sv
// Port-level checker of the chunked body decoder and its bind.
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_macros.svh"

module hcbd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_ready,
	input hcbd_pkg::out_item_t result
);

	logic empty_result;
	logic final_status;

	// Result without a payload byte, and a status that ends the body
	assign empty_result = result_valid && !result.byte_valid;
	assign final_status = (result.status != hcbd_pkg::STATUS_BUSY);

	// A waiting result holds until transfer
	`HCBD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// Non-payload results carry a zero byte
	`HCBD_ASSERT_IMPL(a_empty_byte_zero, empty_result, result.out_byte == 8'h00)

	// Finished exactly on results with a final status
	`HCBD_ASSERT_IMPL(a_finished_status, result_valid, result.finished == final_status)

	// Completion by zero chunk never carries a payload byte
	`HCBD_ASSERT_IMPL(a_ok_no_byte, result_valid && result.status == hcbd_pkg::STATUS_OK, !result.byte_valid)

endmodule

bind http_chunked_body_decoder hcbd_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
